// ===== rtl/olfoc_pkg.sv =====
// ----------------------------------------------------------------------------
// olfoc_pkg - shared definitions of the open-loop FOC phase duty generator
// Widths, fixed-point constants, the quarter-wave sine table, the sequencer
// states and the control words that pass between the modules.
// ----------------------------------------------------------------------------
package olfoc_pkg;

  // Sizing of phase, table and sine values
  localparam int PHASE_BITS      = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_VALUE_BITS = 16;

  // Fixed field widths
  localparam int CMD_W   = 16;
  localparam int CFG_W   = 16;
  localparam int ANGLE_W = 16;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  // Sine table addressing
  localparam int ADDR_W       = SINE_TABLE_BITS + 2;
  localparam int ROM_IDX_W    = SINE_TABLE_BITS + 1;
  localparam int SINE_ENTRIES = (1 << SINE_TABLE_BITS) + 1;
  localparam int SINE_MAG_W   = SINE_VALUE_BITS - 1;
  localparam int SV_W         = SINE_VALUE_BITS;

  // Datapath widths
  localparam int ACC_W        = CMD_W + SV_W;
  localparam int ALPHA_SHIFT  = SV_W - 8;
  localparam int ALPHA_W      = ACC_W - ALPHA_SHIFT;
  localparam int B3_W         = ALPHA_W + 1;
  localparam int X_W          = ALPHA_W + 3;
  localparam int MUL_A_W      = ALPHA_W;
  localparam int MUL_B_W      = 32;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int SQRT3_SHIFT  = 30;
  localparam int DUTY_SHIFT   = 23;
  localparam int NUM_W        = CFG_W + 1 + X_W;
  localparam int QUOT_W       = NUM_W - DUTY_SHIFT;

  localparam logic signed [MUL_B_W-1:0] SQRT3_Q30 = 32'sd1859775393;
  localparam logic signed [X_W-1:0]     DUTY_BIAS = X_W'(1 << 21);
  localparam longint unsigned           PI_HALF_Q30 = 64'd1686629713;

  // Register map, index taken from paddr[2]
  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_PWM_PERIOD = 1'b1;

  localparam logic [CFG_W-1:0] PHASE_STEP_RESET = 16'd3932;
  localparam logic [CFG_W-1:0] PWM_PERIOD_RESET = 16'd1000;

  typedef struct packed {
    logic [CFG_W-1:0] phase_step;
    logic [CFG_W-1:0] pwm_period;
  } cfg_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN_RD,
    ST_COS_RD,
    ST_COS_CAP,
    ST_M_DCS,
    ST_M_QSN,
    ST_M_QCS,
    ST_M_DSN,
    ST_BETA,
    ST_B3,
    ST_UV,
    ST_W,
    ST_D_V,
    ST_D_W,
    ST_D_C,
    ST_DONE
  } state_t;

  typedef logic [SINE_MAG_W-1:0] sine_table_t [SINE_ENTRIES];

  // Quarter-wave sine magnitudes: Taylor series in Q30, rounded half up
  function automatic sine_table_t build_sine_table();
    sine_table_t     tbl;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned r;
    longint unsigned scale;
    longint          s;
    scale = 64'd1 << (SINE_VALUE_BITS - 2);
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      x  = (PI_HALF_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = x;
      s  = $signed(x);
      for (int k = 1; k <= 8; k++) begin
        t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          s = s - $signed(t);
        end else begin
          s = s + $signed(t);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      r = ($unsigned(s) * scale + (64'd1 << 29)) >> 30;
      if (r > scale) begin
        r = scale;
      end
      tbl[i] = SINE_MAG_W'(r);
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

  // Keep the top bits of the phase, or shift it up with zeros
  function automatic logic [ADDR_W-1:0] phase_to_addr(input logic [PHASE_BITS-1:0] ph);
    logic [ADDR_W-1:0] res;
    int                src;
    res = '0;
    for (int b = 0; b < ADDR_W; b++) begin
      src = b + PHASE_BITS - ADDR_W;
      if (src >= 0) begin
        res[b] = ph[src];
      end
    end
    return res;
  endfunction

  function automatic logic [ANGLE_W-1:0] phase_to_angle(input logic [PHASE_BITS-1:0] ph);
    logic [ANGLE_W-1:0] res;
    int                 src;
    res = '0;
    for (int b = 0; b < ANGLE_W; b++) begin
      src = b + PHASE_BITS - ANGLE_W;
      if (src >= 0) begin
        res[b] = ph[src];
      end
    end
    return res;
  endfunction

  // Mirror the index in odd quadrants
  function automatic logic [ROM_IDX_W-1:0] sine_index(input logic [ADDR_W-1:0] addr);
    logic [ROM_IDX_W-1:0] i;
    i = {1'b0, addr[SINE_TABLE_BITS-1:0]};
    if (addr[SINE_TABLE_BITS]) begin
      return ROM_IDX_W'(1 << SINE_TABLE_BITS) - i;
    end
    return i;
  endfunction

endpackage

// ===== rtl/olfoc_sine_rom.sv =====
// ----------------------------------------------------------------------------
// olfoc_sine_rom - quarter-wave sine table
// Constant magnitudes for one quarter turn, read with a registered output.
// ----------------------------------------------------------------------------
module olfoc_sine_rom (
  input  logic                             clk,
  input  logic [olfoc_pkg::ROM_IDX_W-1:0]  rd_addr,
  output logic [olfoc_pkg::SINE_MAG_W-1:0] rd_data
);

  logic [olfoc_pkg::SINE_MAG_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= olfoc_pkg::SINE_TABLE[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/olfoc_mac.sv =====
// ----------------------------------------------------------------------------
// olfoc_mac - shared multiply and accumulate unit
// One signed multiplier with a registered product, and an accumulator that
// loads, adds or subtracts the product under sequencer control.
// ----------------------------------------------------------------------------
module olfoc_mac (
  input  logic                                clk,
  input  olfoc_pkg::mac_ctrl_t                ctrl,
  input  logic signed [olfoc_pkg::MUL_A_W-1:0] mul_a,
  input  logic signed [olfoc_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [olfoc_pkg::PROD_W-1:0]  prod,
  output logic signed [olfoc_pkg::ACC_W-1:0]   acc
);

  logic signed [olfoc_pkg::PROD_W-1:0] prod_r;
  logic signed [olfoc_pkg::ACC_W-1:0]  acc_r;
  logic signed [olfoc_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [olfoc_pkg::ACC_W-1:0]  prod_lo;

  // products feeding the accumulator always fit its width
  assign prod_lo = prod_r[olfoc_pkg::ACC_W-1:0];

  always_comb begin
    case (ctrl.acc_op)
      olfoc_pkg::ACC_LOAD: acc_nxt = prod_lo;
      olfoc_pkg::ACC_ADD:  acc_nxt = acc_r + prod_lo;
      olfoc_pkg::ACC_SUB:  acc_nxt = acc_r - prod_lo;
      default:             acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    acc_r <= acc_nxt;
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

// ===== rtl/olfoc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// olfoc_cfg_regs - configuration registers
// APB-style write and read of the phase step and the PWM period.
// ----------------------------------------------------------------------------
module olfoc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [olfoc_pkg::PADDR_W-1:0]     paddr,
  input  logic [olfoc_pkg::APB_W-1:0]       pwdata,
  output logic [olfoc_pkg::APB_W-1:0]       prdata,
  output logic                              pready,
  output olfoc_pkg::cfg_t                   cfg
);

  olfoc_pkg::cfg_t cfg_r;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step <= olfoc_pkg::PHASE_STEP_RESET;
      cfg_r.pwm_period <= olfoc_pkg::PWM_PERIOD_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        olfoc_pkg::REG_PHASE_STEP: cfg_r.phase_step <= pwdata[olfoc_pkg::CFG_W-1:0];
        olfoc_pkg::REG_PWM_PERIOD: cfg_r.pwm_period <= pwdata[olfoc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      olfoc_pkg::REG_PHASE_STEP: prdata = olfoc_pkg::APB_W'(cfg_r.phase_step);
      olfoc_pkg::REG_PWM_PERIOD: prdata = olfoc_pkg::APB_W'(cfg_r.pwm_period);
      default:                   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/open_loop_foc_phase_duty_generator_core.sv =====
// ----------------------------------------------------------------------------
// open_loop_foc_phase_duty_generator_core - open-loop FOC duty generator
// Flow: a new word is taken only in idle, after the last one has left DONE;
//   the single shared multiplier is stepped through eight products
//   one after another by the sequencer.
// Reset: synchronous active-low; phase accumulator to zero, registers to
//   their defaults, no clearing pass.
// ----------------------------------------------------------------------------
module open_loop_foc_phase_duty_generator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [olfoc_pkg::CMD_W-1:0] in_d_command,
  input  logic signed [olfoc_pkg::CMD_W-1:0] in_q_command,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [olfoc_pkg::ANGLE_W-1:0]     out_electrical_angle,
  output logic [olfoc_pkg::CFG_W-1:0]       out_duty_phase_a,
  output logic [olfoc_pkg::CFG_W-1:0]       out_duty_phase_b,
  output logic [olfoc_pkg::CFG_W-1:0]       out_duty_phase_c,
  output logic                              out_duty_clipped,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [olfoc_pkg::PADDR_W-1:0]     paddr,
  input  logic [olfoc_pkg::APB_W-1:0]       pwdata,
  output logic [olfoc_pkg::APB_W-1:0]       prdata,
  output logic                              pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  olfoc_pkg::cfg_t cfg;

  olfoc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  olfoc_pkg::state_t state_r;
  olfoc_pkg::state_t state_nxt;

  logic in_accept;
  logic out_load;

  // Datapath registers
  logic [olfoc_pkg::PHASE_BITS-1:0]    phase_r;
  logic signed [olfoc_pkg::CMD_W-1:0]  d_r;
  logic signed [olfoc_pkg::CMD_W-1:0]  q_r;
  logic signed [olfoc_pkg::SV_W-1:0]   sn_r;
  logic signed [olfoc_pkg::SV_W-1:0]   cs_r;
  logic signed [olfoc_pkg::ALPHA_W-1:0] alpha_r;
  logic signed [olfoc_pkg::X_W-1:0]    u_r;
  logic signed [olfoc_pkg::X_W-1:0]    v_r;
  logic signed [olfoc_pkg::X_W-1:0]    w_r;
  logic [olfoc_pkg::CFG_W-1:0]         duty_r [3];
  logic                                clip_r;

  // Output register
  logic                                out_valid_r;
  logic [olfoc_pkg::ANGLE_W-1:0]       out_angle_r;
  logic [olfoc_pkg::CFG_W-1:0]         out_duty_r [3];
  logic                                out_clip_r;

  // Per-state strobes
  logic ld_sn;
  logic ld_cs;
  logic ld_alpha;
  logic ld_uv;
  logic ld_w;
  logic ld_duty_a;
  logic ld_duty_b;
  logic ld_duty_c;

  // Shared multiply-accumulate unit
  olfoc_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [olfoc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [olfoc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [olfoc_pkg::PROD_W-1:0]  prod;
  logic signed [olfoc_pkg::ACC_W-1:0]   acc;

  olfoc_mac u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod),
    .acc   (acc)
  );

  // --------------------------------------------------------------------------
  // Sine table: sine address first, cosine a quarter turn later
  // --------------------------------------------------------------------------
  logic [olfoc_pkg::ADDR_W-1:0]     sin_addr;
  logic [olfoc_pkg::ADDR_W-1:0]     cos_addr;
  logic [olfoc_pkg::ROM_IDX_W-1:0]  rom_addr;
  logic [olfoc_pkg::SINE_MAG_W-1:0] rom_data;
  logic signed [olfoc_pkg::SV_W-1:0] rom_mag;

  assign sin_addr = olfoc_pkg::phase_to_addr(phase_r);
  assign cos_addr = sin_addr + olfoc_pkg::ADDR_W'(1 << olfoc_pkg::SINE_TABLE_BITS);
  assign rom_addr = (state_r == olfoc_pkg::ST_COS_RD) ? olfoc_pkg::sine_index(cos_addr)
                                                      : olfoc_pkg::sine_index(sin_addr);
  assign rom_mag  = $signed({1'b0, rom_data});

  olfoc_sine_rom u_sine_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic signed [olfoc_pkg::ALPHA_W-1:0] acc_shifted;
  logic signed [olfoc_pkg::B3_W-1:0]    b3;
  logic signed [olfoc_pkg::X_W-1:0]     alpha_x;
  logic signed [olfoc_pkg::X_W-1:0]     u_nxt;
  logic signed [olfoc_pkg::X_W-1:0]     v_nxt;
  logic signed [olfoc_pkg::X_W-1:0]     w_nxt;

  // floor shift of the sums down to Q20
  assign acc_shifted = acc[olfoc_pkg::ACC_W-1:olfoc_pkg::ALPHA_SHIFT];
  assign b3          = prod[olfoc_pkg::SQRT3_SHIFT +: olfoc_pkg::B3_W];
  assign alpha_x     = olfoc_pkg::X_W'(alpha_r);
  assign u_nxt       = alpha_x <<< 1;
  assign v_nxt       = olfoc_pkg::X_W'(b3) - alpha_x;
  assign w_nxt       = -u_r - v_r;

  // Duty from the product period*(x+bias): truncate toward zero, saturate
  logic signed [olfoc_pkg::NUM_W-1:0]  num;
  logic signed [olfoc_pkg::QUOT_W-1:0] quot;
  logic signed [olfoc_pkg::QUOT_W-1:0] trunc;
  logic                                frac_nz;
  logic                                duty_neg;
  logic                                duty_over;
  logic [olfoc_pkg::CFG_W-1:0]         duty_val;
  logic                                duty_clip;

  assign num       = prod[olfoc_pkg::NUM_W-1:0];
  assign quot      = num[olfoc_pkg::NUM_W-1:olfoc_pkg::DUTY_SHIFT];
  assign frac_nz   = |num[olfoc_pkg::DUTY_SHIFT-1:0];
  assign trunc     = quot + olfoc_pkg::QUOT_W'(num[olfoc_pkg::NUM_W-1] && frac_nz);
  assign duty_neg  = trunc[olfoc_pkg::QUOT_W-1];
  assign duty_over = !duty_neg && (trunc > $signed(olfoc_pkg::QUOT_W'(cfg.pwm_period)));
  assign duty_clip = duty_neg || duty_over;

  always_comb begin
    if (duty_neg) begin
      duty_val = '0;
    end else if (duty_over) begin
      duty_val = cfg.pwm_period;
    end else begin
      duty_val = trunc[olfoc_pkg::CFG_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olfoc_pkg::ST_IDLE:    if (in_valid) state_nxt = olfoc_pkg::ST_SIN_RD;
      olfoc_pkg::ST_SIN_RD:  state_nxt = olfoc_pkg::ST_COS_RD;
      olfoc_pkg::ST_COS_RD:  state_nxt = olfoc_pkg::ST_COS_CAP;
      olfoc_pkg::ST_COS_CAP: state_nxt = olfoc_pkg::ST_M_DCS;
      olfoc_pkg::ST_M_DCS:   state_nxt = olfoc_pkg::ST_M_QSN;
      olfoc_pkg::ST_M_QSN:   state_nxt = olfoc_pkg::ST_M_QCS;
      olfoc_pkg::ST_M_QCS:   state_nxt = olfoc_pkg::ST_M_DSN;
      olfoc_pkg::ST_M_DSN:   state_nxt = olfoc_pkg::ST_BETA;
      olfoc_pkg::ST_BETA:    state_nxt = olfoc_pkg::ST_B3;
      olfoc_pkg::ST_B3:      state_nxt = olfoc_pkg::ST_UV;
      olfoc_pkg::ST_UV:      state_nxt = olfoc_pkg::ST_W;
      olfoc_pkg::ST_W:       state_nxt = olfoc_pkg::ST_D_V;
      olfoc_pkg::ST_D_V:     state_nxt = olfoc_pkg::ST_D_W;
      olfoc_pkg::ST_D_W:     state_nxt = olfoc_pkg::ST_D_C;
      olfoc_pkg::ST_D_C:     state_nxt = olfoc_pkg::ST_DONE;
      olfoc_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) state_nxt = olfoc_pkg::ST_IDLE;
      end
      default:               state_nxt = olfoc_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output logic: operand selection and strobes per state
  // --------------------------------------------------------------------------
  always_comb begin
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = olfoc_pkg::ACC_HOLD;
    mul_a     = '0;
    mul_b     = '0;
    in_accept = 1'b0;
    out_load  = 1'b0;
    ld_sn     = 1'b0;
    ld_cs     = 1'b0;
    ld_alpha  = 1'b0;
    ld_uv     = 1'b0;
    ld_w      = 1'b0;
    ld_duty_a = 1'b0;
    ld_duty_b = 1'b0;
    ld_duty_c = 1'b0;
    case (state_r)
      olfoc_pkg::ST_IDLE:    in_accept = in_valid;
      olfoc_pkg::ST_COS_RD:  ld_sn = 1'b1;
      olfoc_pkg::ST_COS_CAP: ld_cs = 1'b1;
      olfoc_pkg::ST_M_DCS: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a = olfoc_pkg::MUL_A_W'(d_r);
        mul_b = olfoc_pkg::MUL_B_W'(cs_r);
      end
      olfoc_pkg::ST_M_QSN: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = olfoc_pkg::ACC_LOAD;
        mul_a = olfoc_pkg::MUL_A_W'(q_r);
        mul_b = olfoc_pkg::MUL_B_W'(sn_r);
      end
      olfoc_pkg::ST_M_QCS: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = olfoc_pkg::ACC_SUB;
        mul_a = olfoc_pkg::MUL_A_W'(q_r);
        mul_b = olfoc_pkg::MUL_B_W'(cs_r);
      end
      olfoc_pkg::ST_M_DSN: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = olfoc_pkg::ACC_LOAD;
        mul_a    = olfoc_pkg::MUL_A_W'(d_r);
        mul_b    = olfoc_pkg::MUL_B_W'(sn_r);
        ld_alpha = 1'b1;
      end
      olfoc_pkg::ST_BETA:    mac_ctrl.acc_op = olfoc_pkg::ACC_ADD;
      olfoc_pkg::ST_B3: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a = acc_shifted;
        mul_b = olfoc_pkg::SQRT3_Q30;
      end
      olfoc_pkg::ST_UV:      ld_uv = 1'b1;
      olfoc_pkg::ST_W: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a = $signed(olfoc_pkg::MUL_A_W'(cfg.pwm_period));
        mul_b = olfoc_pkg::MUL_B_W'(u_r + olfoc_pkg::DUTY_BIAS);
        ld_w  = 1'b1;
      end
      olfoc_pkg::ST_D_V: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a     = $signed(olfoc_pkg::MUL_A_W'(cfg.pwm_period));
        mul_b     = olfoc_pkg::MUL_B_W'(v_r + olfoc_pkg::DUTY_BIAS);
        ld_duty_a = 1'b1;
      end
      olfoc_pkg::ST_D_W: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a     = $signed(olfoc_pkg::MUL_A_W'(cfg.pwm_period));
        mul_b     = olfoc_pkg::MUL_B_W'(w_r + olfoc_pkg::DUTY_BIAS);
        ld_duty_b = 1'b1;
      end
      olfoc_pkg::ST_D_C:     ld_duty_c = 1'b1;
      olfoc_pkg::ST_DONE:    out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign in_stall = (state_r != olfoc_pkg::ST_IDLE);

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olfoc_pkg::ST_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // advance the phase once per accepted word, wrapping at a full turn
      if (in_accept) begin
        phase_r <= phase_r + olfoc_pkg::PHASE_BITS'(cfg.phase_step);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      d_r <= in_d_command;
      q_r <= in_q_command;
    end
    // negate the table magnitude in the lower half turn
    if (ld_sn) begin
      sn_r <= sin_addr[olfoc_pkg::ADDR_W-1] ? -rom_mag : rom_mag;
    end
    if (ld_cs) begin
      cs_r <= cos_addr[olfoc_pkg::ADDR_W-1] ? -rom_mag : rom_mag;
    end
    if (ld_alpha) begin
      alpha_r <= acc_shifted;
    end
    if (ld_uv) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
    end
    if (ld_w) begin
      w_r <= w_nxt;
    end
    if (ld_duty_a) begin
      duty_r[0] <= duty_val;
      clip_r    <= duty_clip;
    end
    if (ld_duty_b) begin
      duty_r[1] <= duty_val;
      clip_r    <= clip_r | duty_clip;
    end
    if (ld_duty_c) begin
      duty_r[2] <= duty_val;
      clip_r    <= clip_r | duty_clip;
    end
    if (out_load) begin
      out_angle_r   <= olfoc_pkg::phase_to_angle(phase_r);
      out_duty_r[0] <= duty_r[0];
      out_duty_r[1] <= duty_r[1];
      out_duty_r[2] <= duty_r[2];
      out_clip_r    <= clip_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_electrical_angle = out_angle_r;
  assign out_duty_phase_a     = out_duty_r[0];
  assign out_duty_phase_b     = out_duty_r[1];
  assign out_duty_phase_c     = out_duty_r[2];
  assign out_duty_clipped     = out_clip_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=>
      (phase_r == $past(phase_r + olfoc_pkg::PHASE_BITS'(cfg.phase_step))))
    else $error("phase accumulator did not advance by one step");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olfoc_pkg::ST_DONE && out_valid_r && out_stall) |=>
      (state_r == olfoc_pkg::ST_DONE))
    else $error("finished word left the sequencer while the output was busy");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == olfoc_pkg::ST_DONE))
    else $error("output word appeared without a finished sequence");

endmodule
